/* design/rlss_pkg.sv */
package rlss_pkg;

    // led count register width, covers 0 to 511
    localparam int CW = 9;

    // command queue between front and back
    localparam int QDEPTH = 4;
    localparam int QPW    = $clog2(QDEPTH);
    localparam int QCW    = $clog2(QDEPTH + 1);

    localparam logic [7:0] MIN_PERIOD = 8'd2;

    localparam logic [CW-1:0] RST_LED_COUNT  = 9'd8;
    localparam logic [7:0]    RST_BRIGHTNESS = 8'd255;
    localparam logic [7:0]    RST_BIT_PERIOD = 8'd20;
    localparam logic [7:0]    RST_ONE_HIGH   = 8'd12;
    localparam logic [7:0]    RST_ZERO_HIGH  = 8'd4;

    typedef enum logic [2:0] {
        REG_LED_COUNT  = 3'd0,
        REG_BRIGHTNESS = 3'd1,
        REG_BIT_PERIOD = 3'd2,
        REG_ONE_HIGH   = 3'd3,
        REG_ZERO_HIGH  = 3'd4
    } t_reg_idx;

    typedef enum logic [1:0] {
        KIND_SET_ALL = 2'd0,
        KIND_SET_ONE = 2'd1,
        KIND_SHOW    = 2'd2,
        KIND_TICK    = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_FILL,
        OP_WRITE,
        OP_SHOW,
        OP_TICK
    } t_op;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FILL,
        ST_LOAD
    } t_back_st;

    typedef struct packed {
        logic [CW-1:0] led_count;
        logic [7:0]    brightness;
        logic [7:0]    bit_period;
        logic [7:0]    one_high;
        logic [7:0]    zero_high;
    } t_cfg;

    typedef struct packed {
        t_op         op;
        logic [7:0]  pos;
        logic [23:0] color;
    } t_cmd;

    typedef struct packed {
        logic sending;
        logic filling;
    } t_back_stat;

    // floor(p / 255) for p below 65280
    function automatic logic [7:0] div255(input logic [15:0] p);
        logic [15:0] s;
        s = p + {8'd0, p[15:8]} + 16'd1;
        return s[15:8];
    endfunction

endpackage

/* design/rgb_led_strip_serializer_core.sv */
// channel   direction  handshake                          payload
// command   in         start high while busy low          i_kind i_position i_red i_green i_blue
// result    out        o_done high for one cycle          o_line_level o_busy_res
// config    in/out     psel penable pwrite, pready high   paddr pwdata prdata
//
// an accepted command reaches the back end via the multiply stage and the 4-entry queue
// tick, set_one and ignored commands end in the back end idle state; show and a tick that
// starts a new byte also pass the load state (pixel memory read); set_all sweeps leds in use
// results come out in command order; busy rises once queue entries plus multiply stage reach 4
// reset is synchronous and restores the register defaults; the pixel memory is not cleared
// results cannot be stalled: each one is on the ports for exactly one cycle
module rgb_led_strip_serializer_core #(
    parameter int MAX_LEDS = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_kind,
    input  logic [7:0]  i_position,
    input  logic [7:0]  i_red,
    input  logic [7:0]  i_green,
    input  logic [7:0]  i_blue,
    output logic        o_done,
    output logic        o_line_level,
    output logic        o_busy_res,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import rlss_pkg::*;

    t_cfg           w_cfg;
    logic [CW-1:0]  w_n;
    logic           w_push;
    t_cmd           w_cmd;
    t_cmd           w_head;
    logic           w_empty;
    logic [QCW-1:0] w_q_cnt;
    logic           w_pop;
    t_back_stat     w_stat;

    // leds in use, capped at the memory depth
    assign w_n = (32'(w_cfg.led_count) > MAX_LEDS) ? CW'(MAX_LEDS) : w_cfg.led_count;

    rlss_cfg u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (psel),
        .i_penable (penable),
        .i_pwrite  (pwrite),
        .i_paddr   (paddr),
        .i_pwdata  (pwdata),
        .o_prdata  (prdata),
        .o_pready  (pready),
        .o_cfg     (w_cfg)
    );

    rlss_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_kind       (i_kind),
        .i_position   (i_position),
        .i_red        (i_red),
        .i_green      (i_green),
        .i_blue       (i_blue),
        .i_brightness (w_cfg.brightness),
        .i_n          (w_n),
        .i_q_cnt      (w_q_cnt),
        .o_busy       (busy),
        .o_push       (w_push),
        .o_cmd        (w_cmd)
    );

    rlss_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_cmd),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_empty (w_empty),
        .o_cnt   (w_q_cnt)
    );

    rlss_back #(
        .MAX_LEDS (MAX_LEDS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (w_cfg),
        .i_n          (w_n),
        .i_head       (w_head),
        .i_empty      (w_empty),
        .o_pop        (w_pop),
        .o_done       (o_done),
        .o_line_level (o_line_level),
        .o_busy_res   (o_busy_res),
        .o_stat       (w_stat)
    );

    // the busy credit must keep the queue from overflowing
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> (w_q_cnt != QCW'(QDEPTH)))
        else $error("command queue overflow");

    // a fill sweep only runs while no show is sending
    a_fill_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stat.filling |-> !w_stat.sending)
        else $error("fill sweep during transmission");

    // nothing is popped from an empty queue
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_empty)
        else $error("pop from empty queue");

    a_reset_clean: assert property (@(posedge i_clk)
        !i_rst_n |=> (w_q_cnt == '0) && !o_done && !w_stat.sending)
        else $error("state not cleared by reset");

endmodule

/* design/rlss_cfg.sv */
module rlss_cfg (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_psel,
    input  logic            i_penable,
    input  logic            i_pwrite,
    input  logic [4:0]      i_paddr,
    input  logic [31:0]     i_pwdata,
    output logic [31:0]     o_prdata,
    output logic            o_pready,
    output rlss_pkg::t_cfg  o_cfg
);
    import rlss_pkg::*;

    t_cfg     r_cfg;
    t_cfg     n_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign w_idx    = t_reg_idx'(i_paddr[4:2]);
    assign w_wr     = i_psel & i_penable & i_pwrite;
    assign o_pready = 1'b1;
    assign o_cfg    = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (w_wr) begin
            case (w_idx)
                REG_LED_COUNT:  n_cfg.led_count  = i_pwdata[CW-1:0];
                REG_BRIGHTNESS: n_cfg.brightness = i_pwdata[7:0];
                REG_BIT_PERIOD: n_cfg.bit_period = i_pwdata[7:0];
                REG_ONE_HIGH:   n_cfg.one_high   = i_pwdata[7:0];
                REG_ZERO_HIGH:  n_cfg.zero_high  = i_pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_LED_COUNT:  o_prdata = {{(32-CW){1'b0}}, r_cfg.led_count};
            REG_BRIGHTNESS: o_prdata = {24'd0, r_cfg.brightness};
            REG_BIT_PERIOD: o_prdata = {24'd0, r_cfg.bit_period};
            REG_ONE_HIGH:   o_prdata = {24'd0, r_cfg.one_high};
            REG_ZERO_HIGH:  o_prdata = {24'd0, r_cfg.zero_high};
            default:        o_prdata = 32'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.led_count  <= RST_LED_COUNT;
            r_cfg.brightness <= RST_BRIGHTNESS;
            r_cfg.bit_period <= RST_BIT_PERIOD;
            r_cfg.one_high   <= RST_ONE_HIGH;
            r_cfg.zero_high  <= RST_ZERO_HIGH;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

/* design/rlss_front.sv */
module rlss_front (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic [1:0]              i_kind,
    input  logic [7:0]              i_position,
    input  logic [7:0]              i_red,
    input  logic [7:0]              i_green,
    input  logic [7:0]              i_blue,
    input  logic [7:0]              i_brightness,
    input  logic [rlss_pkg::CW-1:0] i_n,
    input  logic [rlss_pkg::QCW-1:0] i_q_cnt,
    output logic                    o_busy,
    output logic                    o_push,
    output rlss_pkg::t_cmd          o_cmd
);
    import rlss_pkg::*;

    logic        r_s1_vld;
    t_kind       r_s1_kind;
    logic [7:0]  r_s1_pos;
    logic [15:0] r_s1_prod_r;
    logic [15:0] r_s1_prod_g;
    logic [15:0] r_s1_prod_b;
    logic        w_acc;
    logic [QCW:0] w_inflight;

    // queue entries plus the item in the multiply stage
    assign w_inflight = (QCW+1)'(i_q_cnt) + (QCW+1)'(r_s1_vld);
    assign o_busy     = (w_inflight >= (QCW+1)'(QDEPTH));
    assign w_acc      = i_start & ~o_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else begin
            r_s1_vld <= w_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_s1_kind   <= t_kind'(i_kind);
            r_s1_pos    <= i_position;
            r_s1_prod_r <= {8'd0, i_red}   * {8'd0, i_brightness};
            r_s1_prod_g <= {8'd0, i_green} * {8'd0, i_brightness};
            r_s1_prod_b <= {8'd0, i_blue}  * {8'd0, i_brightness};
        end
    end

    assign o_push = r_s1_vld;

    always_comb begin
        o_cmd.pos   = r_s1_pos;
        o_cmd.color = {div255(r_s1_prod_g), div255(r_s1_prod_r), div255(r_s1_prod_b)};
        case (r_s1_kind)
            KIND_SET_ALL: o_cmd.op = OP_FILL;
            KIND_SET_ONE: o_cmd.op = ({1'b0, r_s1_pos} < i_n) ? OP_WRITE : OP_NONE;
            KIND_SHOW:    o_cmd.op = OP_SHOW;
            KIND_TICK:    o_cmd.op = OP_TICK;
            default:      o_cmd.op = OP_NONE;
        endcase
    end

endmodule

/* design/rlss_fifo.sv */
module rlss_fifo (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_push,
    input  rlss_pkg::t_cmd           i_cmd,
    input  logic                     i_pop,
    output rlss_pkg::t_cmd           o_head,
    output logic                     o_empty,
    output logic [rlss_pkg::QCW-1:0] o_cnt
);
    import rlss_pkg::*;

    t_cmd           r_buf [QDEPTH];
    logic [QPW-1:0] r_wr_ptr;
    logic [QPW-1:0] r_rd_ptr;
    logic [QCW-1:0] r_cnt;

    assign o_head  = r_buf[r_rd_ptr];
    assign o_empty = (r_cnt == '0);
    assign o_cnt   = r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QPW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + QPW'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + QCW'(1);
                2'b01:   r_cnt <= r_cnt - QCW'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

/* design/rlss_back.sv */
module rlss_back #(
    parameter int MAX_LEDS = 256
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  rlss_pkg::t_cfg          i_cfg,
    input  logic [rlss_pkg::CW-1:0] i_n,
    input  rlss_pkg::t_cmd          i_head,
    input  logic                    i_empty,
    output logic                    o_pop,
    output logic                    o_done,
    output logic                    o_line_level,
    output logic                    o_busy_res,
    output rlss_pkg::t_back_stat    o_stat
);
    import rlss_pkg::*;

    localparam int AW = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;

    logic [23:0]   r_mem [MAX_LEDS];
    logic [23:0]   r_rd_data;

    t_back_st      r_st;
    t_back_st      n_st;
    logic          r_sending,    n_sending;
    logic [CW-1:0] r_pix,        n_pix;
    logic [1:0]    r_chan,       n_chan;
    logic [2:0]    r_bit,        n_bit;
    logic [7:0]    r_tick,       n_tick;
    logic [7:0]    r_shift,      n_shift;
    logic [CW-1:0] r_fill_idx,   n_fill_idx;
    logic [23:0]   r_fill_color, n_fill_color;
    logic          r_load_res,   n_load_res;
    logic          r_done,       n_done;
    logic          r_lvl,        n_lvl;
    logic          r_bsy,        n_bsy;

    logic          w_we;
    logic [AW-1:0] w_waddr;
    logic [23:0]   w_wdata;
    logic          w_re;
    logic [AW-1:0] w_raddr;

    logic [7:0]    w_high;
    logic          w_cur_lvl;
    logic [7:0]    w_period;
    logic [7:0]    w_tick_inc;
    logic          w_bit_end;
    logic          w_byte_end;
    logic          w_pix_end;
    logic [CW-1:0] w_pix_inc;
    logic          w_send_end;
    logic          w_adv_load;
    logic          w_start_ok;
    logic [7:0]    w_load_byte;
    logic [7:0]    w_load_high;

    assign w_high     = r_shift[7] ? i_cfg.one_high : i_cfg.zero_high;
    assign w_cur_lvl  = r_sending & (r_tick < w_high);
    assign w_period   = (i_cfg.bit_period < MIN_PERIOD) ? MIN_PERIOD : i_cfg.bit_period;
    assign w_tick_inc = r_tick + 8'd1;
    assign w_bit_end  = ~(w_tick_inc < w_period);
    assign w_byte_end = w_bit_end & (r_bit == 3'd7);
    assign w_pix_end  = w_byte_end & (r_chan == 2'd2);
    assign w_pix_inc  = r_pix + CW'(1);
    assign w_send_end = w_pix_end & ~(w_pix_inc < i_n);
    assign w_adv_load = r_sending & w_byte_end & ~w_send_end;
    assign w_start_ok = ~r_sending & (i_n != '0);

    // byte order on the line is green, red, blue
    always_comb begin
        case (r_chan)
            2'd0:    w_load_byte = r_rd_data[23:16];
            2'd1:    w_load_byte = r_rd_data[15:8];
            default: w_load_byte = r_rd_data[7:0];
        endcase
    end
    assign w_load_high = w_load_byte[7] ? i_cfg.one_high : i_cfg.zero_high;

    always_comb begin
        n_st = r_st;
        case (r_st)
            ST_IDLE: begin
                if (!i_empty) begin
                    case (i_head.op)
                        OP_FILL: if (w_start_ok) n_st = ST_FILL;
                        OP_SHOW: if (w_start_ok) n_st = ST_LOAD;
                        OP_TICK: if (w_adv_load) n_st = ST_LOAD;
                        default: n_st = ST_IDLE;
                    endcase
                end
            end
            ST_FILL: begin
                if (r_fill_idx == i_n - CW'(1)) n_st = ST_IDLE;
            end
            ST_LOAD: n_st = ST_IDLE;
            default: n_st = ST_IDLE;
        endcase
    end

    always_comb begin
        n_sending    = r_sending;
        n_pix        = r_pix;
        n_chan       = r_chan;
        n_bit        = r_bit;
        n_tick       = r_tick;
        n_shift      = r_shift;
        n_fill_idx   = r_fill_idx;
        n_fill_color = r_fill_color;
        n_load_res   = r_load_res;
        n_done       = 1'b0;
        n_lvl        = r_lvl;
        n_bsy        = r_bsy;
        o_pop        = 1'b0;
        w_we         = 1'b0;
        w_waddr      = AW'(r_fill_idx);
        w_wdata      = r_fill_color;
        w_re         = 1'b0;
        w_raddr      = AW'(r_pix);
        case (r_st)
            ST_IDLE: begin
                if (!i_empty) begin
                    o_pop  = 1'b1;
                    n_done = 1'b1;
                    n_lvl  = w_cur_lvl;
                    n_bsy  = r_sending;
                    case (i_head.op)
                        OP_FILL: begin
                            if (w_start_ok) begin
                                n_fill_idx   = '0;
                                n_fill_color = i_head.color;
                            end
                        end
                        OP_WRITE: begin
                            if (!r_sending) begin
                                w_we    = 1'b1;
                                w_waddr = AW'(i_head.pos);
                                w_wdata = i_head.color;
                            end
                        end
                        OP_SHOW: begin
                            // result waits for the first byte to come out of memory
                            if (w_start_ok) begin
                                n_done     = 1'b0;
                                n_sending  = 1'b1;
                                n_pix      = '0;
                                n_chan     = '0;
                                n_bit      = '0;
                                n_tick     = '0;
                                n_load_res = 1'b1;
                                w_re       = 1'b1;
                                w_raddr    = '0;
                            end
                        end
                        OP_TICK: begin
                            if (r_sending) begin
                                if (!w_bit_end) begin
                                    n_tick = w_tick_inc;
                                end else begin
                                    n_tick  = '0;
                                    n_shift = {r_shift[6:0], 1'b0};
                                    n_bit   = r_bit + 3'd1;
                                    if (w_byte_end) begin
                                        if (w_pix_end) begin
                                            n_chan = '0;
                                            n_pix  = w_pix_inc;
                                        end else begin
                                            n_chan = r_chan + 2'd1;
                                        end
                                        if (w_send_end) begin
                                            n_sending = 1'b0;
                                            n_pix     = '0;
                                            n_shift   = '0;
                                            n_bsy     = 1'b0;
                                        end else begin
                                            n_load_res = 1'b0;
                                            w_re       = 1'b1;
                                            w_raddr    = w_pix_end ? AW'(w_pix_inc) : AW'(r_pix);
                                        end
                                    end
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_FILL: begin
                w_we       = 1'b1;
                n_fill_idx = r_fill_idx + CW'(1);
            end
            ST_LOAD: begin
                n_shift    = w_load_byte;
                n_load_res = 1'b0;
                if (r_load_res) begin
                    n_done = 1'b1;
                    n_lvl  = (w_load_high != 8'd0);
                    n_bsy  = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        if (w_re) begin
            r_rd_data <= r_mem[w_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st       <= ST_IDLE;
            r_sending  <= 1'b0;
            r_pix      <= '0;
            r_chan     <= '0;
            r_bit      <= '0;
            r_tick     <= '0;
            r_shift    <= '0;
            r_load_res <= 1'b0;
            r_done     <= 1'b0;
        end else begin
            r_st       <= n_st;
            r_sending  <= n_sending;
            r_pix      <= n_pix;
            r_chan     <= n_chan;
            r_bit      <= n_bit;
            r_tick     <= n_tick;
            r_shift    <= n_shift;
            r_load_res <= n_load_res;
            r_done     <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_fill_idx   <= n_fill_idx;
        r_fill_color <= n_fill_color;
        r_lvl        <= n_lvl;
        r_bsy        <= n_bsy;
    end

    assign o_done         = r_done;
    assign o_line_level   = r_lvl;
    assign o_busy_res     = r_bsy;
    assign o_stat.sending = r_sending;
    assign o_stat.filling = (r_st == ST_FILL);

endmodule

/* tb/rgb_led_strip_serializer_core_tb.sv */
module rgb_led_strip_serializer_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rlss_pkg::*;

    localparam int STRIP_MAX = 256;
    // a fill of the whole store can still be running when its result has left
    localparam int SETTLE    = STRIP_MAX + 16;

    logic        i_clk;
    logic        i_rst_n    = 1'b0;
    logic        start      = 1'b0;
    logic        busy;
    logic [1:0]  i_kind     = '0;
    logic [7:0]  i_position = '0;
    logic [7:0]  i_red      = '0;
    logic [7:0]  i_green    = '0;
    logic [7:0]  i_blue     = '0;
    logic        o_done;
    logic        o_line_level;
    logic        o_busy_res;
    logic        psel       = 1'b0;
    logic        penable    = 1'b0;
    logic        pwrite     = 1'b0;
    logic [4:0]  paddr      = '0;
    logic [31:0] pwdata     = '0;
    logic [31:0] prdata;
    logic        pready;

    rgb_led_strip_serializer_core u_dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // line predictor: register copy and strip state
    bit [8:0]  cfg_count  = RST_LED_COUNT;
    bit [7:0]  cfg_bright = RST_BRIGHTNESS;
    bit [7:0]  cfg_period = RST_BIT_PERIOD;
    bit [7:0]  cfg_one    = RST_ONE_HIGH;
    bit [7:0]  cfg_zero   = RST_ZERO_HIGH;

    bit [23:0] strip_pixels  [STRIP_MAX];
    bit        strip_written [STRIP_MAX];
    bit        strip_sending;
    int        strip_pixel;
    int        strip_chan;
    int        strip_bit;
    int        strip_ticks;
    bit [7:0]  strip_byte;
    bit        last_effective;

    typedef struct {
        bit line_level;
        bit busy_res;
    } line_sample_t;

    line_sample_t expected_line [$];

    int fails;
    int results_seen;
    int items_sent;
    int effective_items;
    int shows_started;
    int reg_writes;
    int gap_pct = 20;

    function automatic int strip_len();
        return (cfg_count > STRIP_MAX) ? STRIP_MAX : int'(cfg_count);
    endfunction

    function automatic bit [7:0] dim(bit [7:0] v);
        bit [15:0] prod;
        prod = v * cfg_bright;
        return 8'(prod / 16'd255);
    endfunction

    function automatic void fetch_byte();
        bit [23:0] px;
        px = strip_pixels[strip_pixel];
        case (strip_chan)
            0:       strip_byte = px[23:16];
            1:       strip_byte = px[15:8];
            default: strip_byte = px[7:0];
        endcase
    endfunction

    function automatic bit level_now();
        bit [7:0] high_ticks;
        if (!strip_sending) return 1'b0;
        high_ticks = strip_byte[7] ? cfg_one : cfg_zero;
        return strip_ticks < high_ticks;
    endfunction

    function automatic void predict_item(t_kind kind, bit [7:0] pos, bit [7:0] r, g, b);
        line_sample_t want;
        int           period;
        int           n;
        n = strip_len();
        last_effective = 1'b0;
        if (kind == KIND_TICK) begin
            want.line_level = level_now();
            if (strip_sending) begin
                last_effective = 1'b1;
                period = (cfg_period < 2) ? 2 : cfg_period;
                strip_ticks++;
                if (strip_ticks >= period) begin
                    strip_ticks = 0;
                    strip_byte  = strip_byte << 1;
                    strip_bit   = (strip_bit + 1) % 8;
                    if (strip_bit == 0) begin
                        strip_chan++;
                        if (strip_chan == 3) begin
                            strip_chan = 0;
                            strip_pixel++;
                        end
                        if (strip_chan == 0 && strip_pixel >= n) begin
                            strip_sending = 1'b0;
                            strip_pixel   = 0;
                            strip_byte    = '0;
                        end else begin
                            fetch_byte();
                        end
                    end
                end
            end
        end else begin
            if (!strip_sending) begin
                case (kind)
                    KIND_SET_ALL: begin
                        for (int i = 0; i < n; i++) begin
                            strip_pixels[i]  = {dim(g), dim(r), dim(b)};
                            strip_written[i] = 1'b1;
                        end
                        last_effective = (n > 0);
                    end
                    KIND_SET_ONE: begin
                        if (pos < n) begin
                            strip_pixels[pos]  = {dim(g), dim(r), dim(b)};
                            strip_written[pos] = 1'b1;
                            last_effective     = 1'b1;
                        end
                    end
                    default: begin
                        if (n > 0) begin
                            strip_sending  = 1'b1;
                            strip_pixel    = 0;
                            strip_chan     = 0;
                            strip_bit      = 0;
                            strip_ticks    = 0;
                            fetch_byte();
                            last_effective = 1'b1;
                            shows_started++;
                        end
                    end
                endcase
            end
            want.line_level = level_now();
        end
        want.busy_res = strip_sending;
        expected_line.push_back(want);
    endfunction

    always @(posedge i_clk) begin : check_line
        line_sample_t want;
        if (i_rst_n && o_done) begin
            results_seen++;
            if (expected_line.size() == 0) begin
                $error("result with nothing expected: line_level %0b busy_res %0b",
                       o_line_level, o_busy_res);
                fails++;
            end else begin
                want = expected_line.pop_front();
                if (o_line_level !== want.line_level) begin
                    $error("line_level: expected %0b, got %0b", want.line_level, o_line_level);
                    fails++;
                end
                if (o_busy_res !== want.busy_res) begin
                    $error("busy_res: expected %0b, got %0b", want.busy_res, o_busy_res);
                    fails++;
                end
            end
        end
    end

    task automatic send_cmd(t_kind kind, bit [7:0] pos, bit [7:0] r, g, b);
        bit ready;
        int gap;
        ready = 1'b1;
        if (kind == KIND_SHOW && !strip_sending) begin
            for (int i = 0; i < strip_len(); i++)
                if (!strip_written[i]) ready = 1'b0;
            // never send a pixel that was not written, fill the strip instead
            if (!ready) kind = KIND_SET_ALL;
        end
        i_kind     <= kind;
        i_position <= pos;
        i_red      <= r;
        i_green    <= g;
        i_blue     <= b;
        start      <= 1'b1;
        do @(posedge i_clk); while (busy);
        predict_item(kind, pos, r, g, b);
        items_sent++;
        if (last_effective) effective_items++;
        if ($urandom_range(0, 99) < gap_pct) begin
            gap = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3) : $urandom_range(8, 24);
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_tick();
        send_cmd(KIND_TICK, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    endtask

    task automatic run_out();
        while (strip_sending) send_tick();
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        while (expected_line.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic cfg_write(t_reg_idx idx, bit [31:0] value);
        bit [31:0] mask;
        mask = (idx == REG_LED_COUNT) ? 32'h1FF : 32'hFF;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        // read back in the same selection
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== (value & mask)) begin
            $error("register %s: expected %0h, got %0h", idx.name(), value & mask, prdata);
            fails++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_LED_COUNT:  cfg_count  = value[8:0];
            REG_BRIGHTNESS: cfg_bright = value[7:0];
            REG_BIT_PERIOD: cfg_period = value[7:0];
            REG_ONE_HIGH:   cfg_one    = value[7:0];
            default:        cfg_zero   = value[7:0];
        endcase
        reg_writes++;
    endtask

    task automatic configure(bit [8:0] count, bit [7:0] bright, period, one, zero);
        wait_idle();
        cfg_write(REG_LED_COUNT, 32'(count));
        cfg_write(REG_BRIGHTNESS, 32'(bright));
        cfg_write(REG_BIT_PERIOD, 32'(period));
        cfg_write(REG_ONE_HIGH, 32'(one));
        cfg_write(REG_ZERO_HIGH, 32'(zero));
    endtask

    task automatic test_defaults();
        send_tick();
        send_cmd(KIND_SET_ALL, 8'h00, 8'hFF, 8'h00, 8'hAA);
        send_cmd(KIND_SET_ONE, 8'h00, 8'h00, 8'hFF, 8'h55);
        send_cmd(KIND_SET_ONE, 8'h07, 8'hFF, 8'hFF, 8'hFF);
        send_cmd(KIND_SET_ONE, 8'h08, 8'h12, 8'h34, 8'h56);
        // default bit timing on a single pixel
        wait_idle();
        cfg_write(REG_LED_COUNT, 32'd1);
        send_cmd(KIND_SHOW, 8'h00, 8'h00, 8'h00, 8'h00);
        // commands during a send have no effect
        send_cmd(KIND_SET_ONE, 8'h01, 8'h00, 8'h00, 8'h00);
        send_cmd(KIND_SET_ALL, 8'hFF, 8'h00, 8'h00, 8'h00);
        send_cmd(KIND_SHOW, 8'h00, 8'h00, 8'h00, 8'h00);
        run_out();
    endtask

    task automatic test_brightness();
        configure(9'd2, 8'd0, 8'd2, 8'd1, 8'd1);
        send_cmd(KIND_SET_ALL, 8'h00, 8'hFF, 8'hFF, 8'hFF);
        configure(9'd2, 8'd128, 8'd2, 8'd1, 8'd1);
        send_cmd(KIND_SET_ONE, 8'h01, 8'hFF, 8'h80, 8'h01);
        send_cmd(KIND_SHOW, 8'h00, 8'h00, 8'h00, 8'h00);
        run_out();
    endtask

    task automatic test_zero_count();
        configure(9'd0, 8'd255, 8'd2, 8'd1, 8'd1);
        send_cmd(KIND_SHOW, 8'h00, 8'h00, 8'h00, 8'h00);
        send_tick();
        send_cmd(KIND_SET_ALL, 8'h00, 8'h11, 8'h22, 8'h33);
        send_cmd(KIND_SET_ONE, 8'h00, 8'h44, 8'h55, 8'h66);
    endtask

    task automatic test_high_times();
        // high time beyond the period, and a zero high time
        configure(9'd1, 8'd255, 8'd3, 8'd255, 8'd0);
        send_cmd(KIND_SET_ONE, 8'h00, 8'hA5, 8'h3C, 8'h0F);
        send_cmd(KIND_SHOW, 8'h00, 8'h00, 8'h00, 8'h00);
        run_out();
        // periods below the minimum act as two ticks
        configure(9'd1, 8'd200, 8'd0, 8'd1, 8'd2);
        send_cmd(KIND_SHOW, 8'h00, 8'h00, 8'h00, 8'h00);
        run_out();
        configure(9'd1, 8'd255, 8'd1, 8'd2, 8'd0);
        send_cmd(KIND_SHOW, 8'h00, 8'h00, 8'h00, 8'h00);
        run_out();
    endtask

    task automatic test_long_strip();
        // count beyond the store size is clipped to the store
        configure(9'd511, 8'd255, 8'd2, 8'd2, 8'd1);
        send_cmd(KIND_SET_ALL, 8'h00, 8'h5A, 8'hC3, 8'h81);
        send_cmd(KIND_SET_ONE, 8'hFF, 8'h01, 8'h80, 8'hFE);
        configure(9'd256, 8'd77, 8'd2, 8'd2, 8'd1);
        send_cmd(KIND_SET_ONE, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        send_cmd(KIND_SET_ONE, 8'h00, 8'h00, 8'h00, 8'h00);
    endtask

    task automatic test_random();
        int       phase_base;
        int       n;
        int       pick;
        int       period;
        t_kind    kind;
        bit [7:0] pos;
        for (int p = 0; p < 3; p++) begin
            period = $urandom_range(0, 4);
            configure(9'($urandom_range(1, 2)), 8'($urandom), 8'(period),
                      8'($urandom_range(0, period + 2)), 8'($urandom_range(0, period + 2)));
            gap_pct    = (p == 1) ? 0 : ((p == 2) ? 60 : 25);
            phase_base = effective_items;
            while (effective_items - phase_base < 40) begin
                n    = strip_len();
                pick = $urandom_range(0, 99);
                if (strip_sending)
                    kind = (pick < 90) ? KIND_TICK : t_kind'($urandom_range(0, 2));
                else if (pick < 25)
                    kind = KIND_SET_ONE;
                else if (pick < 35)
                    kind = KIND_SET_ALL;
                else if (pick < 60)
                    kind = KIND_SHOW;
                else
                    kind = KIND_TICK;
                pos = ($urandom_range(0, 99) < 70) ? 8'($urandom_range(0, n - 1)) : 8'($urandom);
                send_cmd(kind, pos, 8'($urandom), 8'($urandom), 8'($urandom));
            end
            run_out();
        end
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_defaults();
        test_brightness();
        test_zero_count();
        test_high_times();
        test_long_strip();
        test_random();
        wait_idle();
        $display("summary: %0d command transfers, %0d changed state, %0d shows, %0d reg writes",
                 items_sent, effective_items, shows_started, reg_writes);
        $display("summary: %0d line results compared, %0d mismatches", results_seen, fails);
        if (fails == 0 && expected_line.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        #10ms;
        $display("timeout with %0d results outstanding", expected_line.size());
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

/* rgb_led_strip_serializer_core.f */
design/rlss_pkg.sv
design/rlss_cfg.sv
design/rlss_front.sv
design/rlss_fifo.sv
design/rlss_back.sv
design/rgb_led_strip_serializer_core.sv
tb/rgb_led_strip_serializer_core_tb.sv
